// ===== rtl/gb3_pkg.sv =====
// gb3_pkg: shared constants and types for the 3x3 binomial blur block
// no dependencies; imported by the interfaces, the window unit and the top level
`timescale 1ns / 1ps

package gb3_pkg;

  // line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // field and register widths
  localparam int PIX_W   = 8;
  localparam int WID_W   = 11;
  localparam int HGT_W   = 12;
  localparam int ROW_W   = HGT_W + 1;
  localparam int SUM_W   = PIX_W + 4;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // register reset values and limits
  localparam logic [WID_W-1:0] WIDTH_RESET  = WID_W'(640);
  localparam logic [HGT_W-1:0] HEIGHT_RESET = HGT_W'(480);
  localparam logic [WID_W-1:0] WIDTH_MIN    = WID_W'(3);
  localparam logic [WID_W-1:0] WIDTH_MAX    = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] HEIGHT_MIN   = HGT_W'(3);

  // register index, taken from paddr bit 2
  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_t;

  // source of an output pixel
  typedef enum logic [2:0] {
    SEL_CORNER = 3'b001,
    SEL_CENTER = 3'b010,
    SEL_BLUR   = 3'b100
  } out_sel_t;

  // one window column, top row is the oldest line
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } column_t;

endpackage

// ===== rtl/gb3_pixel_if.sv =====
// gb3_pixel_if: valid/ready channel for input pixels and flush items
// depends on gb3_pkg
`timescale 1ns / 1ps

interface gb3_pixel_if import gb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             is_flush;

  modport source (output valid, pixel_in, is_flush, input ready);
  modport sink   (input valid, pixel_in, is_flush, output ready);
endinterface

// ===== rtl/gb3_result_if.sv =====
// gb3_result_if: valid/ready channel for blurred output pixels
// depends on gb3_pkg
`timescale 1ns / 1ps

interface gb3_result_if import gb3_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;

  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink   (input valid, pixel_out, frame_last, output ready);
endinterface

// ===== rtl/gb3_ram.sv =====
// gb3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module gb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/gb3_window.sv =====
// gb3_window: two older window columns plus the incoming one, 1-2-1 x 1-2-1 kernel
// depends on gb3_pkg
`timescale 1ns / 1ps

module gb3_window import gb3_pkg::*; (
  input  logic             clk,
  input  logic             shift,
  input  column_t          col_new,
  output logic [PIX_W-1:0] center,
  output logic [PIX_W-1:0] blur
);

  column_t col_old;   // left column of the window
  column_t col_mid;   // middle column of the window

  logic [SUM_W-1:0] sum_top;
  logic [SUM_W-1:0] sum_mid;
  logic [SUM_W-1:0] sum_bot;
  logic [SUM_W-1:0] sum_all;

  // shift the window one column on every step
  always_ff @(posedge clk) begin
    if (shift) begin
      col_old <= col_mid;
      col_mid <= col_new;
    end
  end

  // horizontal 1-2-1 per row, then vertical 1-2-1
  always_comb begin
    sum_top = SUM_W'(col_old.top) + SUM_W'({col_mid.top, 1'b0}) + SUM_W'(col_new.top);
    sum_mid = SUM_W'(col_old.mid) + SUM_W'({col_mid.mid, 1'b0}) + SUM_W'(col_new.mid);
    sum_bot = SUM_W'(col_old.bot) + SUM_W'({col_mid.bot, 1'b0}) + SUM_W'(col_new.bot);
    sum_all = sum_top + SUM_W'({sum_mid, 1'b0}) + sum_bot;
  end

  // divide by 16 with truncation
  assign blur   = sum_all[SUM_W-1:4];
  assign center = col_mid.mid;

endmodule

// ===== rtl/gaussian_blur_3x3.sv =====
// gaussian_blur_3x3: 3x3 binomial blur over a raster pixel stream
// depends on gb3_pkg, gb3_pixel_if, gb3_result_if, gb3_ram, gb3_window
//
//   channel   dir  handshake        payload
//   pixels    in   valid / ready    pixel_in[7:0], is_flush
//   results   out  valid / ready    pixel_out[7:0], frame_last
//   apb       in   psel / penable   paddr[2:0], pwdata[31:0] -> prdata[31:0]
//
// one item per cycle sustained while results are taken; each result is registered through
// the line store read, then the window and output register, one row plus one pixel later in
// the stream. the line store is one ram holding both previous rows side by side.
// reset restores 640 x 480 and restarts the frame; line stores need no clearing pass,
// since every entry that reaches an output was written earlier in the same frame.
// a full output register only stalls input when the item in the read stage has a result.
`timescale 1ns / 1ps

module gaussian_blur_3x3 import gb3_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  gb3_pixel_if.sink           pixels,
  gb3_result_if.source        results,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration
  logic [WID_W-1:0] image_width;
  logic [HGT_W-1:0] image_height;
  logic [WID_W-1:0] eff_width;
  logic [HGT_W-1:0] eff_height;
  logic [COL_W-1:0] col_end;
  logic [ROW_W-1:0] row_h;
  logic [ROW_W-1:0] row_h_p1;
  reg_idx_t         reg_idx;
  logic             cfg_wr;

  // input position
  logic [COL_W-1:0] in_column;
  logic [ROW_W-1:0] in_row;

  // accept stage
  logic             draining;
  logic             accept;
  logic             step;
  logic             col_zero;
  logic             col_last;
  logic             has_res;
  logic             is_last;
  logic [PIX_W-1:0] pix;
  out_sel_t         sel;

  // read stage
  logic             s1_valid;
  logic [COL_W-1:0] s1_col;
  logic [PIX_W-1:0] s1_pix;
  logic             s1_has;
  logic             s1_last;
  logic             s1_col_last;
  out_sel_t         s1_sel;
  logic             s1_adv;

  // line store and window
  logic [2*PIX_W-1:0] ram_rdata;
  logic [PIX_W-1:0]   row_b_old;
  logic [PIX_W-1:0]   row_a_old;
  column_t            col_new;
  logic [PIX_W-1:0]   corner;
  logic [PIX_W-1:0]   center;
  logic [PIX_W-1:0]   blur;
  logic [PIX_W-1:0]   value;

  // output register
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             out_last;

  // apb port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_WIDTH:  image_width  <= pwdata[WID_W-1:0];
        REG_HEIGHT: image_height <= pwdata[HGT_W-1:0];
        default:    image_width  <= image_width;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_WIDTH:  prdata = PDATA_W'(image_width);
      REG_HEIGHT: prdata = PDATA_W'(image_height);
      default:    prdata = '0;
    endcase
  end

  // effective frame size
  always_comb begin
    if (image_width < WIDTH_MIN) begin
      eff_width = WIDTH_MIN;
    end else if (image_width > WIDTH_MAX) begin
      eff_width = WIDTH_MAX;
    end else begin
      eff_width = image_width;
    end
    eff_height = (image_height < HEIGHT_MIN) ? HEIGHT_MIN : image_height;
    col_end    = COL_W'(eff_width - WID_W'(1));
    row_h      = ROW_W'(eff_height);
    row_h_p1   = ROW_W'(eff_height) + ROW_W'(1);
  end

  // accept stage decode
  always_comb begin
    draining = in_row >= row_h;
    accept   = pixels.valid && pixels.ready;
    step     = accept && (!pixels.is_flush || draining);
    pix      = draining ? '0 : pixels.pixel_in;
    col_zero = in_column == '0;
    col_last = in_column == col_end;
    has_res  = col_zero ? (in_row >= ROW_W'(2)) : (in_row >= ROW_W'(1));
    is_last  = col_zero && (in_row == row_h_p1);
    if (col_zero) begin
      sel = SEL_CORNER;
    end else if (in_row == ROW_W'(1) || in_row == row_h || in_column == COL_W'(1)) begin
      sel = SEL_CENTER;
    end else begin
      sel = SEL_BLUR;
    end
  end

  assign s1_adv       = s1_valid && (!s1_has || !out_valid || results.ready);
  assign pixels.ready = !s1_valid || s1_adv;

  // input position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      in_column <= '0;
      in_row    <= '0;
    end else if (step) begin
      if (is_last) begin
        in_column <= '0;
        in_row    <= '0;
      end else if (col_last) begin
        in_column <= '0;
        in_row    <= in_row + ROW_W'(1);
      end else begin
        in_column <= in_column + COL_W'(1);
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (step) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (step) begin
      s1_col      <= in_column;
      s1_pix      <= pix;
      s1_has      <= has_res;
      s1_last     <= is_last;
      s1_col_last <= col_last;
      s1_sel      <= sel;
    end
  end

  // line store: upper byte is the older row, lower byte the previous row
  gb3_ram #(
    .WIDTH (2 * PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_col),
    .wdata ({row_a_old, s1_pix}),
    .re    (step),
    .raddr (in_column),
    .rdata (ram_rdata)
  );

  assign row_b_old   = ram_rdata[2*PIX_W-1:PIX_W];
  assign row_a_old   = ram_rdata[PIX_W-1:0];
  assign col_new.top = row_b_old;
  assign col_new.mid = row_a_old;
  assign col_new.bot = s1_pix;

  gb3_window u_window (
    .clk     (clk),
    .shift   (s1_adv),
    .col_new (col_new),
    .center  (center),
    .blur    (blur)
  );

  // last pixel of the older row, the output at the start of each new row
  always_ff @(posedge clk) begin
    if (s1_adv && s1_col_last) begin
      corner <= row_a_old;
    end
  end

  // output value select
  always_comb begin
    case (s1_sel)
      SEL_CORNER: value = corner;
      SEL_CENTER: value = center;
      SEL_BLUR:   value = blur;
      default:    value = center;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_has) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has) begin
      out_pixel <= value;
      out_last  <= s1_last;
    end
  end

  assign results.valid      = out_valid;
  assign results.pixel_out  = out_pixel;
  assign results.frame_last = out_last;

endmodule

// ===== dv/tb_gaussian_blur_3x3.sv =====
// tb_gaussian_blur_3x3: self-checking bench for the 3x3 binomial blur, with a scoreboard
// depends on gb3_pkg, gb3_pixel_if, gb3_result_if and the gaussian_blur_3x3 rtl
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3;
  import gb3_pkg::*;

  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AFTER    = 120;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 420;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } blur_result_t;

  // blur predictor and queue of pending output pixels
  class blur_scoreboard;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [PIX_W-1:0] prev_row [MAX_WIDTH];
    logic [PIX_W-1:0] older_row [MAX_WIDTH];
    logic [PIX_W-1:0] win [9];
    int unsigned      col;
    int unsigned      row;
    blur_result_t     expected_q [$];
    int unsigned      accepted;
    int unsigned      checked;
    int unsigned      frames_done;
    int unsigned      errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (prev_row[i]) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      restart_frame();
      accepted    = 0;
      checked     = 0;
      frames_done = 0;
      errors      = 0;
    endfunction

    function void restart_frame();
      col = 0;
      row = 0;
    endfunction

    function int unsigned frame_width();
      int unsigned w;
      w = width_reg;
      if (w < WIDTH_MIN) w = WIDTH_MIN;
      if (w > WIDTH_MAX) w = WIDTH_MAX;
      return w;
    endfunction

    function int unsigned frame_height();
      return (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    endfunction

    function logic [PDATA_W-1:0] reg_value(reg_idx_t idx);
      return (idx == REG_WIDTH) ? PDATA_W'(width_reg) : PDATA_W'(height_reg);
    endfunction

    // any register write restarts the frame, stores keep their contents
    function void write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
      case (idx)
        REG_WIDTH:  width_reg  = value[WID_W-1:0];
        REG_HEIGHT: height_reg = value[HGT_W-1:0];
        default: ;
      endcase
      restart_frame();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // accepted input transfer: advance window and stores, queue any output pixel
    function void note_pixel(logic [PIX_W-1:0] px, logic flush);
      int unsigned  w, h, c, r, orow, ocol, sum;
      logic [PIX_W-1:0] pin, corner, value;
      bit           draining, has_out, last;
      w = frame_width();
      h = frame_height();
      draining = (row >= h);
      // flush before the frame is complete does nothing
      if (flush && !draining) return;
      c = col;
      r = row;
      if (c >= w) begin
        restart_frame();
        return;
      end
      accepted++;
      // pixel values during drain are discarded
      pin = draining ? '0 : px;
      corner = older_row[w-1];

      for (int k = 0; k < 3; k++) begin
        win[k*3]   = win[k*3+1];
        win[k*3+1] = win[k*3+2];
      end
      win[2] = older_row[c];
      win[5] = prev_row[c];
      win[8] = pin;
      older_row[c] = prev_row[c];
      prev_row[c]  = pin;

      if (c + 1 >= w) begin
        col = 0;
        row = r + 1;
      end else begin
        col = c + 1;
      end

      // output position trails the input by one row plus one pixel
      if (c >= 1) begin
        has_out = (r >= 1);
        orow = r - 1;
        ocol = c - 1;
      end else begin
        has_out = (r >= 2);
        orow = r - 2;
        ocol = w - 1;
      end
      if (!has_out) return;

      if (c == 0) begin
        value = corner;
      end else if (orow == 0 || orow == h - 1 || ocol == 0 || ocol == w - 1) begin
        value = win[4];
      end else begin
        // 1-2-1 by 1-2-1 kernel, divide by 16 with truncation
        sum = win[0] + win[2] + win[6] + win[8]
            + 2 * (win[1] + win[3] + win[5] + win[7])
            + 4 * win[4];
        value = PIX_W'(sum >> 4);
      end
      last = (orow == h - 1) && (ocol == w - 1);
      expected_q.push_back('{pixel: value, last: last});
      if (last) begin
        restart_frame();
        frames_done++;
      end
    endfunction

    // result transfer: compare with the oldest pending output pixel
    function void check_result(logic [PIX_W-1:0] px, logic last);
      blur_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("unexpected result %0d: pixel_out=%0d frame_last=%0b", checked, px, last);
        return;
      end
      want = expected_q.pop_front();
      if (px !== want.pixel) begin
        errors++;
        $error("result %0d pixel_out: expected %0d, got %0d", checked, want.pixel, px);
      end
      if (last !== want.last) begin
        errors++;
        $error("result %0d frame_last: expected %0b, got %0b", checked, want.last, last);
      end
    endfunction

    function void report_leftover();
      if (expected_q.size() != 0) begin
        errors++;
        $error("%0d output pixels never arrived", expected_q.size());
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  gb3_pixel_if  pix_ch ();
  gb3_result_if res_ch ();

  blur_scoreboard sb = new();

  bit          quiet;
  int unsigned used_items;
  int unsigned reg_writes;
  int unsigned settings;
  int unsigned read_errors;

  gaussian_blur_3x3 dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_ch),
    .results (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // input and result transfers
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) sb.note_pixel(pix_ch.pixel_in, pix_ch.is_flush);
  end

  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) sb.check_result(res_ch.pixel_out, res_ch.frame_last);
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // extremes show up often
  function automatic logic [PIX_W-1:0] pick_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic logic [PADDR_W-1:0] reg_addr(reg_idx_t idx);
    return PADDR_W'({idx, 2'b00});
  endfunction

  // receiver: random stalls, one long hold-off while the sender keeps going
  initial begin : receiver
    int unsigned gap, burst;
    bit          held;
    held = 1'b0;
    res_ch.ready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if (!held && sb.checked >= HOLD_AFTER && pix_ch.valid) begin
        held = 1'b1;
        res_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      gap = idle_gap();
      if (gap != 0) begin
        res_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_ch.ready = 1'b1;
      burst = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (burst) @(negedge clk);
    end
  end

  // one input transfer, after an optional gap
  task automatic send_item(logic [PIX_W-1:0] value, logic flush);
    int unsigned gap;
    gap = quiet ? 0 : idle_gap();
    @(negedge clk);
    if (gap != 0) begin
      pix_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_ch.valid    = 1'b1;
    pix_ch.pixel_in = value;
    pix_ch.is_flush = flush;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  // drop valid, let all pending output pixels arrive, then let the pipeline settle
  task automatic wait_drained();
    @(negedge clk);
    pix_ch.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, logic [PDATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = reg_addr(idx);
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    reg_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_check(reg_idx_t idx);
    logic [PDATA_W-1:0] want;
    want = sb.reg_value(idx);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = reg_addr(idx);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      read_errors++;
      $error("register %s prdata: expected %0d, got %0d", idx.name(), want, prdata);
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // new frame geometry, written only when the block is idle
  task automatic configure(bit set_w, int unsigned w, bit set_h, int unsigned h);
    wait_drained();
    if (set_w) begin
      apb_write(REG_WIDTH, PDATA_W'(w));
      apb_check(REG_WIDTH);
    end
    if (set_h) begin
      apb_write(REG_HEIGHT, PDATA_W'(h));
      apb_check(REG_HEIGHT);
    end
    settings++;
  endtask

  // one frame in raster order plus its drain, cut short after stop_at items
  task automatic send_frame(int unsigned stop_at, bit noisy);
    int unsigned w, h, npix, total;
    w = sb.frame_width();
    h = sb.frame_height();
    npix  = w * h;
    total = npix + w + 1;
    if (stop_at > total) stop_at = total;
    for (int unsigned i = 0; i < stop_at; i++) begin
      if (i < npix) begin
        // stray flush inside the frame is ignored
        if (noisy && $urandom_range(0, 29) == 0) send_item(PIX_W'($urandom), 1'b1);
        send_item(pick_pixel(), 1'b0);
      end else begin
        // drain items: flush or a pixel whose value is dropped
        send_item(pick_pixel(), $urandom_range(0, 3) != 0);
      end
      used_items++;
    end
    // flush after the frame has drained belongs to the next frame and is ignored
    if (noisy && stop_at == total && $urandom_range(0, 4) == 0)
      send_item(PIX_W'($urandom), 1'b1);
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0] pattern [9];
    int unsigned      start, fw, fh, total, stop_at, nframes, which, roll;

    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    pix_ch.is_flush = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    quiet      = 1'b0;
    used_items = 0;
    reg_writes = 0;
    settings   = 0;
    read_errors = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset geometry
    apb_check(REG_WIDTH);
    apb_check(REG_HEIGHT);

    // smallest frame, checkerboard, flushes at every frame phase
    configure(1'b1, 3, 1'b1, 3);
    pattern = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
    send_item(8'hA5, 1'b1);
    for (int i = 0; i < 9; i++) begin
      if (i == 5) send_item(8'h5A, 1'b1);
      send_item(pattern[i], 1'b0);
    end
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b1);
    send_item(8'hFF, 1'b1);

    // register values out of range saturate, full frames at each
    configure(1'b1, 2, 1'b1, 0);
    send_frame(32'hFFFF_FFFF, 1'b1);
    configure(1'b1, 0, 1'b1, 1);
    send_frame(32'hFFFF_FFFF, 1'b1);
    configure(1'b1, 1, 1'b1, 2);
    send_frame(32'hFFFF_FFFF, 1'b0);

    // widest line and tallest frame, cut shortly after the first row wraps
    configure(1'b1, 2047, 1'b1, 4095);
    send_frame(MAX_WIDTH + 24, 1'b1);

    // random geometries, mostly small complete frames, some cut short
    start = used_items;
    while (used_items - start < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 19);
      if (roll == 0) fw = $urandom_range(0, 2);
      else if (roll == 1) fw = $urandom_range(17, 64);
      else if (roll == 2) fw = $urandom_range(1025, 2047);
      else fw = $urandom_range(3, 16);
      roll = $urandom_range(0, 19);
      if (roll == 0) fh = $urandom_range(0, 2);
      else if (roll == 1) fh = $urandom_range(9, 4095);
      else fh = $urandom_range(3, 8);
      which = $urandom_range(0, 3);
      configure(which != 1, fw, which != 0, fh);

      quiet = ($urandom_range(0, 3) == 0);
      nframes = $urandom_range(1, 3);
      for (int n = 0; n < nframes; n++) begin
        total = sb.frame_width() * sb.frame_height() + sb.frame_width() + 1;
        if (total > 600 || $urandom_range(0, 7) == 0)
          stop_at = $urandom_range(1, (total < 400) ? total : 400);
        else
          stop_at = total;
        send_frame(stop_at, 1'b1);
        if (stop_at < total) break;
      end
      quiet = 1'b0;
    end

    wait_drained();
    sb.report_leftover();
    $display("covered %0d effective input transfers, %0d output pixels, %0d complete frames",
             sb.accepted, sb.checked, sb.frames_done);
    $display("%0d register writes over %0d geometry settings, with random stalls on both sides",
             reg_writes, settings);
    if (sb.errors == 0 && read_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
